// ----- sv/fpa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, action codes and latency constants of the fixed-point arithmetic unit.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DIV_STEPS     = 32;
    localparam int DIV_LAT       = DIV_STEPS + 2;
    localparam int FAST_LAT      = 3;
    localparam int ITEM_LAT      = DIV_LAT + 1;

    localparam logic signed [63:0] MAX_POS = 64'sd2147483647;
    localparam logic signed [63:0] MIN_NEG = -64'sd2147483648;
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [3:0] {
        ACT_ADD        = 4'd0,
        ACT_SUB        = 4'd1,
        ACT_MUL        = 4'd2,
        ACT_DIV        = 4'd3,
        ACT_MIN        = 4'd4,
        ACT_MAX        = 4'd5,
        ACT_CMP        = 4'd6,
        ACT_INC        = 4'd7,
        ACT_DEC        = 4'd8,
        ACT_FROM_INT   = 4'd9,
        ACT_FROM_FLOAT = 4'd10,
        ACT_TO_INT     = 4'd11,
        ACT_TO_FLOAT   = 4'd12
    } t_action;

    typedef enum logic [1:0] {
        FC_ZERO,
        FC_NORM,
        FC_LIMIT,
        FC_NAN
    } t_fcls;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [31:0] result;
        logic        a_less;
        logic        a_equal;
        logic        a_greater;
        logic        divide_by_zero;
        logic        saturated;
    } t_out;

    typedef struct packed {
        logic [31:0] result;
        logic        saturated;
    } t_part;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_flags;

endpackage

// ----- sv/fpa_arith.sv -----
`timescale 1ns / 1ps
// Three-stage integer path: add, sub, mul, min, max, inc, dec, int conversions and compare flags.
module fpa_arith
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  t_in    i_item,
    output t_part  o_part,
    output t_flags o_flags
);

    localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] n_p;
    logic signed [63:0] n_v;
    logic signed [63:0] n_v2;
    t_flags             n_f;
    t_part              n_part;

    logic signed [63:0] r_p;
    logic signed [63:0] r_v;
    logic signed [63:0] r_v2;
    logic [3:0]         r_act;
    t_flags             r_f1;
    t_flags             r_f2;
    t_part              r_part;
    t_flags             r_f3;

    assign a   = i_item.operand_a;
    assign b   = i_item.operand_b;
    assign n_p = a * b;

    always_comb begin
        n_v = '0;
        case (i_item.action)
            ACT_ADD:      n_v = 64'(a) + 64'(b);
            ACT_SUB:      n_v = 64'(a) - 64'(b);
            ACT_MIN:      n_v = (a < b) ? 64'(a) : 64'(b);
            ACT_MAX:      n_v = (a > b) ? 64'(a) : 64'(b);
            ACT_INC:      n_v = 64'(a) + 64'sd1;
            ACT_DEC:      n_v = 64'(a) - 64'sd1;
            ACT_FROM_INT: n_v = 64'(a) <<< FRAC_BITS;
            ACT_TO_INT:   n_v = 64'(a >>> FRAC_BITS);
            default:      n_v = '0;
        endcase
        n_f.lt = a < b;
        n_f.eq = a == b;
        n_f.gt = a > b;
    end

    always_comb begin
        if (r_act == ACT_MUL) begin
            n_v2 = (r_p + (r_p[63] ? BIAS : 64'sd0)) >>> FRAC_BITS;
        end else begin
            n_v2 = r_v;
        end
    end

    always_comb begin
        if (r_v2 > MAX_POS) begin
            n_part.result    = SAT_POS;
            n_part.saturated = 1'b1;
        end else if (r_v2 < MIN_NEG) begin
            n_part.result    = SAT_NEG;
            n_part.saturated = 1'b1;
        end else begin
            n_part.result    = r_v2[31:0];
            n_part.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_v    <= n_v;
        r_act  <= i_item.action;
        r_f1   <= n_f;
        r_v2   <= n_v2;
        r_f2   <= r_f1;
        r_part <= n_part;
        r_f3   <= r_f2;
    end

    assign o_part  = r_part;
    assign o_flags = r_f3;

endmodule

// ----- sv/fpa_conv.sv -----
`timescale 1ns / 1ps
// Three-stage IEEE single conversions in both directions.
module fpa_conv
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  t_in   i_item,
    output t_part o_part
);

    localparam logic [7:0] EXP_BIAS = 8'(127 - FRAC_BITS);

    logic [7:0]        ex;
    logic [7:0]        exu;
    logic [22:0]       fr;
    logic [23:0]       man;
    logic signed [9:0] sh;
    t_fcls             n_cls;
    logic [31:0]       n_tmag;

    t_fcls             r_cls;
    logic              r_fneg;
    logic [23:0]       r_man;
    logic signed [9:0] r_sh;
    logic              r_tneg;
    logic [31:0]       r_tmag;
    logic [3:0]        r_act1;

    logic [4:0]        k;
    logic [63:0]       n_mag;
    logic [4:0]        n_tp;

    t_fcls             r_cls2;
    logic              r_fneg2;
    logic [63:0]       r_mag;
    logic              r_tneg2;
    logic [31:0]       r_tmag2;
    logic [4:0]        r_tp;
    logic              r_tz;
    logic [3:0]        r_act2;

    t_part             n_from;
    logic [31:0]       n_to;
    logic [31:0]       nm;
    logic [24:0]       m25;
    logic              up;
    logic [7:0]        n_ex;
    t_part             r_part;

    assign ex  = i_item.operand_a[30:23];
    assign fr  = i_item.operand_a[22:0];
    assign man = {ex != 8'd0, fr};
    assign exu = (ex == 8'd0) ? 8'd1 : ex;
    assign sh  = $signed({2'b00, exu} + 10'(FRAC_BITS) - 10'd150);

    always_comb begin
        if (ex == 8'hFF) begin
            n_cls = (fr != 23'd0) ? FC_NAN : FC_LIMIT;
        end else if (man == 24'd0) begin
            n_cls = FC_ZERO;
        end else if (sh >= 10'sd40) begin
            n_cls = FC_LIMIT;
        end else if (sh < -10'sd25) begin
            n_cls = FC_ZERO;
        end else begin
            n_cls = FC_NORM;
        end
        n_tmag = i_item.operand_a[31] ? (32'd0 - i_item.operand_a) : i_item.operand_a;
    end

    always_comb begin
        k = 5'(-r_sh);
        if (r_sh >= 10'sd0) begin
            n_mag = {40'd0, r_man} << r_sh[5:0];
        end else begin
            n_mag = ({40'd0, r_man} + (64'd1 << 5'(k - 5'd1))) >> k;
        end
        n_tp = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_tmag[i]) begin
                n_tp = 5'(i);
            end
        end
    end

    always_comb begin
        n_from = '{result: 32'd0, saturated: 1'b0};
        case (r_cls2)
            FC_NAN:   n_from = '{result: 32'd0, saturated: 1'b1};
            FC_LIMIT: n_from = '{result: r_fneg2 ? SAT_NEG : SAT_POS, saturated: 1'b1};
            FC_NORM: begin
                if (r_fneg2) begin
                    if (r_mag > 64'h8000_0000) begin
                        n_from = '{result: SAT_NEG, saturated: 1'b1};
                    end else begin
                        n_from = '{result: 32'(64'd0 - r_mag), saturated: 1'b0};
                    end
                end else if (r_mag > 64'h7FFF_FFFF) begin
                    n_from = '{result: SAT_POS, saturated: 1'b1};
                end else begin
                    n_from = '{result: r_mag[31:0], saturated: 1'b0};
                end
            end
            default:  n_from = '{result: 32'd0, saturated: 1'b0};
        endcase

        nm   = r_tmag2 << (5'd31 - r_tp);
        up   = nm[7] && ((nm[6:0] != 7'd0) || nm[8]);
        m25  = {1'b0, nm[31:8]} + {24'd0, up};
        n_ex = 8'(r_tp) + EXP_BIAS + {7'd0, m25[24]};
        if (r_tz) begin
            n_to = 32'd0;
        end else begin
            n_to = {r_tneg2, n_ex, m25[24] ? 23'd0 : m25[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_fneg  <= i_item.operand_a[31];
        r_man   <= man;
        r_sh    <= sh;
        r_tneg  <= i_item.operand_a[31];
        r_tmag  <= n_tmag;
        r_act1  <= i_item.action;

        r_cls2  <= r_cls;
        r_fneg2 <= r_fneg;
        r_mag   <= n_mag;
        r_tneg2 <= r_tneg;
        r_tmag2 <= r_tmag;
        r_tp    <= n_tp;
        r_tz    <= r_tmag == 32'd0;
        r_act2  <= r_act1;

        if (r_act2 == ACT_TO_FLOAT) begin
            r_part <= '{result: n_to, saturated: 1'b0};
        end else begin
            r_part <= n_from;
        end
    end

    assign o_part = r_part;

endmodule

// ----- sv/fpa_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with sign fix and clamp.
module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  t_in   i_item,
    output t_part o_part,
    output logic  o_dz
);

    localparam int NW = 32 + FRAC_BITS;

    logic [31:0]   na;
    logic [31:0]   nb;
    logic [NW-1:0] num;

    logic [31:0] r_rem [DIV_STEPS];
    logic [31:0] r_low [DIV_STEPS];
    logic [31:0] r_q   [DIV_STEPS+1];
    logic [31:0] r_d   [DIV_STEPS+1];
    logic        r_neg [DIV_STEPS+1];
    logic        r_ovf [DIV_STEPS+1];
    logic        r_dz  [DIV_STEPS+1];

    t_part n_part;
    t_part r_part;
    logic  r_dzo;

    assign na  = i_item.operand_a[31] ? (32'd0 - i_item.operand_a) : i_item.operand_a;
    assign nb  = i_item.operand_b[31] ? (32'd0 - i_item.operand_b) : i_item.operand_b;
    assign num = {na, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_rem[0] <= 32'(num[NW-1:32]);
        r_low[0] <= num[31:0];
        r_q[0]   <= '0;
        r_d[0]   <= nb;
        r_neg[0] <= i_item.operand_a[31] ^ i_item.operand_b[31];
        r_ovf[0] <= 32'(num[NW-1:32]) >= nb;
        r_dz[0]  <= i_item.operand_b == 32'd0;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [32:0] rr;
        logic        ge;
        assign rr = {r_rem[g], r_low[g][31]};
        assign ge = rr >= {1'b0, r_d[g]};
        always_ff @(posedge i_clk) begin
            r_q[g+1]   <= {r_q[g][30:0], ge};
            r_d[g+1]   <= r_d[g];
            r_neg[g+1] <= r_neg[g];
            r_ovf[g+1] <= r_ovf[g];
            r_dz[g+1]  <= r_dz[g];
        end
        if (g < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[g+1] <= ge ? 32'(rr - {1'b0, r_d[g]}) : rr[31:0];
                r_low[g+1] <= {r_low[g][30:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_dz[DIV_STEPS]) begin
            n_part = '{result: 32'd0, saturated: 1'b0};
        end else if (r_ovf[DIV_STEPS]) begin
            n_part = '{result: r_neg[DIV_STEPS] ? SAT_NEG : SAT_POS, saturated: 1'b1};
        end else if (r_neg[DIV_STEPS]) begin
            if (r_q[DIV_STEPS] > 32'h8000_0000) begin
                n_part = '{result: SAT_NEG, saturated: 1'b1};
            end else begin
                n_part = '{result: 32'd0 - r_q[DIV_STEPS], saturated: 1'b0};
            end
        end else if (r_q[DIV_STEPS] > 32'h7FFF_FFFF) begin
            n_part = '{result: SAT_POS, saturated: 1'b1};
        end else begin
            n_part = '{result: r_q[DIV_STEPS], saturated: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_dzo  <= r_dz[DIV_STEPS];
    end

    assign o_part = r_part;
    assign o_dz   = r_dzo;

endmodule

// ----- sv/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// Top level of the pipelined signed fixed-point arithmetic unit.
//
//  channel | ports                     | handshake
//  --------+---------------------------+--------------------------------------
//  input   | i_item (t_in)             | taken at an edge with start && !busy
//  output  | o_result (t_out)          | o_done high one cycle, always taken
//
// One item enters every cycle; busy stays low. Each result's delay is set by the
// 32-stage divider plus its input and sign-fix stages; the shorter paths are
// delayed to match so order holds.
// Synchronous active-low reset clears the valid pipe; items in flight drop.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_done,
    output t_out o_result
);

    localparam int DLY = DIV_LAT - FAST_LAT;

    t_part  ar_part;
    t_flags ar_flags;
    t_part  cv_part;
    t_part  dv_part;
    logic   dv_dz;

    logic [DIV_LAT-1:0] r_vld;
    logic [3:0]         r_act [DIV_LAT];
    t_part              r_fp  [DLY];
    t_flags             r_ff  [DLY];
    logic               r_done;
    t_out               r_out;

    t_part n_fast;
    t_out  n_out;

    fpa_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
        .i_clk   (i_clk),
        .i_item  (i_item),
        .o_part  (ar_part),
        .o_flags (ar_flags)
    );

    fpa_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
        .i_clk  (i_clk),
        .i_item (i_item),
        .o_part (cv_part)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_item (i_item),
        .o_part (dv_part),
        .o_dz   (dv_dz)
    );

    assign busy = 1'b0;

    always_comb begin
        if (r_act[FAST_LAT-1] == ACT_FROM_FLOAT || r_act[FAST_LAT-1] == ACT_TO_FLOAT) begin
            n_fast = cv_part;
        end else begin
            n_fast = ar_part;
        end
        n_out.a_less    = r_ff[DLY-1].lt;
        n_out.a_equal   = r_ff[DLY-1].eq;
        n_out.a_greater = r_ff[DLY-1].gt;
        if (r_act[DIV_LAT-1] == ACT_DIV) begin
            n_out.result         = dv_part.result;
            n_out.saturated      = dv_part.saturated;
            n_out.divide_by_zero = dv_dz;
        end else begin
            n_out.result         = r_fp[DLY-1].result;
            n_out.saturated      = r_fp[DLY-1].saturated;
            n_out.divide_by_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[DIV_LAT-2:0], start && !busy};
            r_done <= r_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_act[0] <= i_item.action;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_act[i] <= r_act[i-1];
        end
        r_fp[0] <= n_fast;
        r_ff[0] <= ar_flags;
        for (int i = 1; i < DLY; i++) begin
            r_fp[i] <= r_fp[i-1];
            r_ff[i] <= r_ff[i-1];
        end
        r_out <= n_out;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// ----- sv/fpa_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the fixed-point arithmetic unit and its bind.
module fpa_chk
    import fpa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_item,
    input logic o_done,
    input t_out o_result
);

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_rst_n, ITEM_LAT))
        else $error("result without an item");

    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##ITEM_LAT o_done)
        else $error("item lost");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot({o_result.a_less, o_result.a_equal, o_result.a_greater}))
        else $error("compare flags not one-hot");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.divide_by_zero) |->
            (o_result.result == 32'd0 && !o_result.saturated))
        else $error("zero divisor result not cleared");

endmodule

bind fixed_point_alu fpa_chk u_fpa_chk (.*);

// ----- dv/fixed_point_alu_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the fixed-point arithmetic unit: directed and random items.
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1750;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_done;
    t_out o_result;

    t_in  pending_items[$];
    t_out expected_results[$];
    int   mismatch_count;
    int   unexpected_count;
    bit   stimulus_done;
    int   idle_left;
    bit   no_idle;

    fixed_point_alu #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_done(o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return SAT_POS;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return SAT_NEG;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] float_to_fixed(input logic [31:0] bits, inout logic sat);
        logic        neg;
        int          ex;
        logic [63:0] man;
        logic [63:0] mag;
        int          shift;
        int          k;
        neg = bits[31];
        ex  = int'(bits[30:23]);
        man = {41'd0, bits[22:0]};
        if (ex == 255) begin
            sat = 1'b1;
            if (man != 0) return 32'd0;
            return neg ? SAT_NEG : SAT_POS;
        end
        if (ex != 0) man[23] = 1'b1;
        else ex = 1;
        if (man == 0) return 32'd0;
        shift = ex - 150 + FB;
        if (shift >= 0) begin
            if (shift >= 40) begin
                sat = 1'b1;
                return neg ? SAT_NEG : SAT_POS;
            end
            mag = man << shift;
        end else begin
            k = -shift;
            if (k > 25) return 32'd0;
            mag = (man + (64'd1 << (k - 1))) >> k;
        end
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                sat = 1'b1;
                return SAT_NEG;
            end
            return 32'd0 - mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return SAT_POS;
        end
        return mag[31:0];
    endfunction

    function automatic logic [31:0] fixed_to_float(input logic signed [31:0] v);
        logic        sgn;
        logic [63:0] mag;
        logic [63:0] man;
        logic [63:0] rem;
        logic [63:0] half;
        int          p;
        int          r;
        logic [7:0]  ex;
        sgn = v[31];
        mag = sgn ? 64'd0 - {{32{v[31]}}, v} : {32'd0, v};
        if (mag == 0) return 32'd0;
        p = 0;
        while (p < 63 && (mag >> (p + 1)) != 0) p++;
        if (p <= 23) begin
            man = mag << (23 - p);
        end else begin
            r    = p - 23;
            rem  = mag & ((64'd1 << r) - 1);
            half = 64'd1 << (r - 1);
            man  = mag >> r;
            if (rem > half || (rem == half && man[0])) man++;
            if (man == (64'd1 << 24)) begin
                man = man >> 1;
                p++;
            end
        end
        ex = 8'(p - FB + 127);
        return {sgn, ex, man[22:0]};
    endfunction

    function automatic t_out alu_predict(input t_in it);
        t_out                 o;
        logic signed [127:0]  a;
        logic signed [127:0]  b;
        logic signed [127:0]  q;
        logic                 sat;
        a = $signed(it.operand_a);
        b = $signed(it.operand_b);
        sat = 1'b0;
        o = '0;
        case (it.action)
            ACT_ADD:  o.result = clamp_word(a + b, sat);
            ACT_SUB:  o.result = clamp_word(a - b, sat);
            ACT_MUL: begin
                q = (a * b) / (128'sd1 <<< FB);
                o.result = clamp_word(q, sat);
            end
            ACT_DIV: begin
                if (b == 0) begin
                    o.divide_by_zero = 1'b1;
                end else begin
                    q = (a * (128'sd1 <<< FB)) / b;
                    o.result = clamp_word(q, sat);
                end
            end
            ACT_MIN:        o.result = (a < b) ? it.operand_a : it.operand_b;
            ACT_MAX:        o.result = (a > b) ? it.operand_a : it.operand_b;
            ACT_CMP:        o.result = 32'd0;
            ACT_INC:        o.result = clamp_word(a + 1, sat);
            ACT_DEC:        o.result = clamp_word(a - 1, sat);
            ACT_FROM_INT:   o.result = clamp_word(a * (128'sd1 <<< FB), sat);
            ACT_FROM_FLOAT: o.result = float_to_fixed(it.operand_a, sat);
            ACT_TO_INT:     o.result = $signed(it.operand_a) >>> FB;
            ACT_TO_FLOAT:   o.result = fixed_to_float(it.operand_a);
            default:        o.result = 32'd0;
        endcase
        o.saturated = sat;
        o.a_less    = a < b;
        o.a_equal   = a == b;
        o.a_greater = a > b;
        return o;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return $urandom_range(0, 2047) - 1024;
            4: return $urandom & 32'h0000_FFFF;
            5: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_float();
        logic [7:0] ex;
        case ($urandom_range(0, 5))
            0: ex = 8'hFF;
            1: ex = 8'h00;
            2: ex = 8'($urandom);
            default: ex = 8'($urandom_range(100, 165));
        endcase
        return {1'($urandom), ex, 23'($urandom)};
    endfunction

    task automatic add_item(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b);
        t_in it;
        it.action    = act;
        it.operand_a = a;
        it.operand_b = b;
        pending_items.push_back(it);
    endtask

    initial begin
        t_in it;
        logic [3:0] act;
        add_item(ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        add_item(ACT_SUB, 32'h8000_0000, 32'h0000_0001);
        add_item(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(ACT_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        add_item(ACT_DIV, 32'h0000_0100, 32'h0000_0000);
        add_item(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        add_item(ACT_DIV, 32'hFFFF_FD00, 32'h0000_0200);
        add_item(ACT_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(ACT_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(ACT_CMP, 32'h1234_5678, 32'h1234_5678);
        add_item(ACT_INC, 32'h7FFF_FFFF, 32'h0);
        add_item(ACT_DEC, 32'h8000_0000, 32'h0);
        add_item(ACT_FROM_INT, 32'h0080_0000, 32'h0);
        add_item(ACT_FROM_INT, 32'hFF80_0000, 32'h0);
        add_item(ACT_FROM_FLOAT, 32'h7FC0_0000, 32'h0);
        add_item(ACT_FROM_FLOAT, 32'hFF80_0000, 32'h0);
        add_item(ACT_FROM_FLOAT, 32'h7F80_0000, 32'h0);
        add_item(ACT_FROM_FLOAT, 32'h8000_0000, 32'h0);
        add_item(ACT_FROM_FLOAT, 32'h3B00_0000, 32'h0);
        add_item(ACT_FROM_FLOAT, 32'hBFC0_0000, 32'h0);
        add_item(ACT_TO_INT, 32'hFFFF_FF01, 32'h0);
        add_item(ACT_TO_FLOAT, 32'h7FFF_FFFF, 32'h0);
        add_item(ACT_TO_FLOAT, 32'h8000_0000, 32'h0);
        add_item(4'd13, 32'hFFFF_FFFF, 32'h0);
        add_item(4'd15, 32'h0, 32'hFFFF_FFFF);
        for (int n = 0; n < N_RANDOM; n++) begin
            act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
            it.action    = act;
            it.operand_a = (act == ACT_FROM_FLOAT) ? random_float() : random_operand();
            it.operand_b = ($urandom_range(0, 7) == 0) ? it.operand_a : random_operand();
            pending_items.push_back(it);
        end
        stimulus_done = 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_item    <= '0;
            idle_left <= 0;
        end else begin
            no_idle = pending_items.size() < 300;
            if (start && !busy) begin
                expected_results.push_back(alu_predict(i_item));
            end
            if (start && busy) begin
                // hold the item until taken
            end else if (idle_left > 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (pending_items.size() > 0) begin
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    start     <= 1'b0;
                    idle_left <= $urandom_range(0, 10);
                end else begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result %h", o_result);
            end else begin
                want = expected_results.pop_front();
                if (want !== o_result) begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("mismatch: expected %h actual %h", want, o_result);
                end
            end
        end
    end

    initial begin
        i_item = '0;
        start = 1'b0;
        mismatch_count = 0;
        unexpected_count = 0;
        wait (stimulus_done && pending_items.size() == 0);
        @(posedge i_clk);
        @(posedge i_clk);
        wait (expected_results.size() == 0 && !start);
        repeat (ITEM_LAT + 10) @(posedge i_clk);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
